@@ sv/task_path_sequencer_core_macros.svh @@
// assertion macros of the task path sequencer core
`ifndef TASK_PATH_SEQUENCER_CORE_MACROS_SVH
`define TASK_PATH_SEQUENCER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked while out of reset
`define TPS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("task path sequencer check failed");
// checked on every edge, reset included
`define TPS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("task path sequencer reset check failed");
`else
`define TPS_ASSERT(lbl, clk, rst_n, prop)
`define TPS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ sv/tps_pkg.sv @@
// shared types, constants and helpers of the task path sequencer
`timescale 1ns / 1ps
package tps_pkg;

  // table geometry
  localparam int PATHS       = 8;
  localparam int SLOTS       = 16;
  localparam int PATH_W      = $clog2(PATHS);
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int ROW_AW      = PATH_W + 1;
  localparam int COL_AW      = SLOT_W + 1;
  localparam int TABLE_DEPTH = PATHS * SLOTS;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  // beat field widths
  localparam int CMD_W      = 2;
  localparam int ACT_W      = 3;
  localparam int TGT_W      = 3;
  localparam int EROW_W     = 3;
  localparam int ESLOT_W    = 4;
  localparam int TASK_W     = 4;
  localparam int OUT_PATH_W = 3;
  localparam int OUT_SLOT_W = 4;

  // first path that sequencing wraps to
  localparam logic [PATH_W-1:0] FIRST_PATH = PATH_W'(1);

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE   = 2'd0,
    CMD_MONITOR = 2'd1,
    CMD_START   = 2'd2
  } cmd_e;

  // monitor action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_NONE         = 3'd0,
    ACT_RESTART_TASK = 3'd1,
    ACT_RESTART_PATH = 3'd2,
    ACT_SKIP_TASK    = 3'd3,
    ACT_SKIP_PATH    = 3'd4
  } act_e;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    DP_IDLE,
    DP_LOAD,
    DP_WRITE,
    DP_RD_CUR,
    DP_RD_TGT,
    DP_RD_SKIP,
    DP_ADV_A,
    DP_ADV_B,
    DP_ADV_C,
    DP_ADV_D,
    DP_COMMIT_TGT,
    DP_COMMIT_SKIP
  } dp_op_e;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [ACT_W-1:0]   action;
    logic               task_done;
    logic [TGT_W-1:0]   target_path;
    logic [EROW_W-1:0]  entry_row;
    logic [ESLOT_W-1:0] entry_slot;
    logic [TASK_W-1:0]  entry_task;
  } item_t;

  typedef struct packed {
    logic                  dispatch;
    logic [TASK_W-1:0]     task_index;
    logic [OUT_PATH_W-1:0] path_now;
    logic [OUT_SLOT_W-1:0] slot_now;
  } result_t;

  typedef struct packed {
    dp_op_e op;
    logic   dispatch;
  } dp_ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [ACT_W-1:0] action;
    logic             task_done;
    logic             rd_zero;
  } dp_status_t;

  // flat table index of a row and slot
  function automatic logic [IDX_W-1:0] tab_idx(logic [PATH_W-1:0] r, logic [SLOT_W-1:0] c);
    return IDX_W'(int'(r) * SLOTS + int'(c));
  endfunction

endpackage

@@ sv/tps_ctrl.sv @@
// sequencing controller of the task path sequencer
`timescale 1ns / 1ps
module tps_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  tps_pkg::dp_status_t   status_i,
  output tps_pkg::dp_ctrl_t     ctrl_o,
  output logic                  busy_o,
  output logic                  done_o
);
  import tps_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_TGT   = 4'd2;
  localparam logic [3:0] S_SKIP  = 4'd3;
  localparam logic [3:0] S_ADV_A = 4'd4;
  localparam logic [3:0] S_ADV_B = 4'd5;
  localparam logic [3:0] S_ADV_C = 4'd6;
  localparam logic [3:0] S_ADV_D = 4'd7;
  localparam logic [3:0] S_RESP  = 4'd8;

  logic [3:0] state_q, state_d;
  logic       disp_q, disp_d;
  dp_op_e     op;

  // next state and datapath command
  always_comb begin
    state_d = state_q;
    disp_d  = disp_q;
    op      = DP_IDLE;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op      = DP_LOAD;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        state_d = S_RESP;
        disp_d  = 1'b0;
        case (status_i.command)
          CMD_WRITE: begin
            op = DP_WRITE;
          end
          CMD_START: begin
            op      = DP_RD_CUR;
            state_d = S_ADV_A;
            disp_d  = 1'b1;
          end
          CMD_MONITOR: begin
            case (status_i.action)
              ACT_NONE: begin
                if (status_i.task_done) begin
                  op      = DP_RD_CUR;
                  state_d = S_ADV_A;
                  disp_d  = 1'b1;
                end
              end
              ACT_RESTART_TASK: begin
                disp_d = 1'b1;
              end
              ACT_RESTART_PATH: begin
                op      = DP_RD_TGT;
                state_d = S_TGT;
                disp_d  = 1'b1;
              end
              ACT_SKIP_TASK: begin
                op      = DP_RD_CUR;
                state_d = S_ADV_A;
                disp_d  = 1'b1;
              end
              ACT_SKIP_PATH: begin
                op      = DP_RD_SKIP;
                state_d = S_SKIP;
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      S_TGT: begin
        op      = DP_COMMIT_TGT;
        state_d = S_RESP;
      end
      S_SKIP: begin
        op      = DP_COMMIT_SKIP;
        state_d = S_RESP;
      end
      S_ADV_A: begin
        op      = DP_ADV_A;
        state_d = status_i.rd_zero ? S_ADV_B : S_ADV_C;
      end
      S_ADV_B: begin
        op      = DP_ADV_B;
        state_d = S_ADV_C;
      end
      S_ADV_C: begin
        op      = DP_ADV_C;
        state_d = status_i.rd_zero ? S_ADV_D : S_RESP;
      end
      S_ADV_D: begin
        op      = DP_ADV_D;
        state_d = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      disp_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      disp_q  <= disp_d;
    end
  end

  assign ctrl_o.op       = op;
  assign ctrl_o.dispatch = disp_q;
  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = (state_q == S_RESP);

endmodule

@@ sv/tps_datapath.sv @@
// path table, position registers and step logic of the task path sequencer
`timescale 1ns / 1ps
module tps_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tps_pkg::item_t      item_i,
  input  tps_pkg::dp_ctrl_t   ctrl_i,
  output tps_pkg::dp_status_t status_o,
  output tps_pkg::result_t    result_o
);
  import tps_pkg::*;

  item_t              item_q;
  logic [PATH_W-1:0]  path_q, path_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [TASK_W-1:0]  task_q, task_d;
  logic [ROW_AW-1:0]  wp_q, wp_d;
  logic [COL_AW-1:0]  ws_q, ws_d;
  logic [TASK_W-1:0]  wt_q, wt_d;

  logic [TASK_W-1:0]      mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_q;
  logic [TASK_W-1:0]      mem_rd_q;
  logic                   rd_ok_q;
  logic [TASK_W-1:0]      rdata;
  logic                   rd_zero;

  logic [ROW_AW-1:0] rd_row, wr_row;
  logic [COL_AW-1:0] rd_col, wr_col;
  logic              rd_in, wr_in, wr_en;
  logic [IDX_W-1:0]  rd_idx, wr_idx;

  // registered read beat, unwritten or off-table entries read as zero
  assign rdata   = rd_ok_q ? mem_rd_q : '0;
  assign rd_zero = (rdata == '0);

  // read address for the operation in flight
  always_comb begin
    rd_row = '0;
    rd_col = '0;
    case (ctrl_i.op)
      DP_RD_CUR: begin
        rd_row = ROW_AW'(path_q);
        rd_col = COL_AW'(slot_q);
      end
      DP_RD_TGT: begin
        rd_row = ROW_AW'(item_q.target_path);
      end
      DP_RD_SKIP: begin
        rd_row = ROW_AW'(path_q) + ROW_AW'(1);
      end
      DP_ADV_A: begin
        if (rd_zero) begin
          rd_row = ROW_AW'(FIRST_PATH);
        end else begin
          rd_row = wp_q;
          rd_col = ws_q + COL_AW'(1);
        end
      end
      DP_ADV_B: begin
        rd_row = ROW_AW'(FIRST_PATH);
        rd_col = COL_AW'(1);
      end
      DP_ADV_C: begin
        rd_row = wp_q + ROW_AW'(1);
      end
      default: ;
    endcase
  end

  assign rd_in  = (rd_row < ROW_AW'(PATHS)) && (rd_col < COL_AW'(SLOTS));
  assign rd_idx = tab_idx(PATH_W'(rd_row), SLOT_W'(rd_col));

  // table write port
  assign wr_row = ROW_AW'(item_q.entry_row);
  assign wr_col = COL_AW'(item_q.entry_slot);
  assign wr_in  = (wr_row < ROW_AW'(PATHS)) && (wr_col < COL_AW'(SLOTS));
  assign wr_idx = tab_idx(PATH_W'(wr_row), SLOT_W'(wr_col));
  assign wr_en  = (ctrl_i.op == DP_WRITE) && wr_in;

  // table storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx] <= item_q.entry_task;
    end
    mem_rd_q <= mem[rd_idx];
  end

  // entry valid bits and read qualifier
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_q[wr_idx] <= 1'b1;
      end
      rd_ok_q <= rd_in && valid_q[rd_idx];
    end
  end

  // step logic for positions and working copies
  always_comb begin
    path_d = path_q;
    slot_d = slot_q;
    task_d = task_q;
    wp_d   = wp_q;
    ws_d   = ws_q;
    wt_d   = wt_q;
    case (ctrl_i.op)
      DP_RD_CUR: begin
        wp_d = ROW_AW'(path_q);
        ws_d = COL_AW'(slot_q);
      end
      DP_RD_SKIP: begin
        wp_d = ROW_AW'(path_q) + ROW_AW'(1);
      end
      DP_ADV_A: begin
        if (rd_zero) begin
          wp_d = ROW_AW'(FIRST_PATH);
          ws_d = '0;
        end else begin
          wt_d = rdata;
          ws_d = ws_q + COL_AW'(1);
        end
      end
      DP_ADV_B: begin
        wt_d = rdata;
        ws_d = COL_AW'(1);
      end
      DP_ADV_C: begin
        if (rd_zero) begin
          wp_d = wp_q + ROW_AW'(1);
          ws_d = '0;
        end else begin
          task_d = wt_q;
          path_d = PATH_W'(wp_q);
          slot_d = SLOT_W'(ws_q);
        end
      end
      DP_ADV_D: begin
        task_d = wt_q;
        path_d = rd_zero ? FIRST_PATH : PATH_W'(wp_q);
        slot_d = '0;
      end
      DP_COMMIT_TGT: begin
        path_d = PATH_W'(item_q.target_path);
        task_d = rdata;
        slot_d = SLOT_W'(1);
      end
      DP_COMMIT_SKIP: begin
        path_d = rd_zero ? FIRST_PATH : PATH_W'(wp_q);
        slot_d = '0;
      end
      default: ;
    endcase
  end

  // sequencing position registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_q <= FIRST_PATH;
      slot_q <= '0;
      task_q <= '0;
    end else begin
      path_q <= path_d;
      slot_q <= slot_d;
      task_q <= task_d;
    end
  end

  // input beat capture and working registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == DP_LOAD) begin
      item_q <= item_i;
    end
    wp_q <= wp_d;
    ws_q <= ws_d;
    wt_q <= wt_d;
  end

  assign status_o.command   = item_q.command;
  assign status_o.action    = item_q.action;
  assign status_o.task_done = item_q.task_done;
  assign status_o.rd_zero   = rd_zero;

  assign result_o.dispatch   = ctrl_i.dispatch;
  assign result_o.task_index = task_q;
  assign result_o.path_now   = OUT_PATH_W'(path_q);
  assign result_o.slot_now   = OUT_SLOT_W'(slot_q);

endmodule

@@ sv/task_path_sequencer_core.sv @@
// top level of the task path sequencer
// Usage: drive item_i and raise start; the beat is taken on a rising edge
// with start high and busy low. Commands write a path table entry, apply a
// monitor action (none, restart task, restart path, skip task, skip path)
// or start sequencing with one advance.
// Each beat gives exactly one result beat on result_o, marked by
// result_valid_o for one cycle; the receiver cannot hold it off, and the
// result registers keep their value until the next step.
// A write or a command without a table read goes from decode straight to
// the result strobe; restart path and skip path first pass a commit state,
// and an advance passes states A and C, plus B and D on zero reads.
// busy falls the cycle after the strobe. An advance makes up to four
// dependent reads through the single registered read port of the table.
// Reset (rst_ni low, asynchronous) clears the table through per-entry valid
// bits at once, sets the current path to 1, the slot and the task to 0,
// and leaves the block idle; there is no clearing pass.
`timescale 1ns / 1ps
`include "task_path_sequencer_core_macros.svh"
module task_path_sequencer_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  tps_pkg::item_t   item_i,
  output logic             result_valid_o,
  output tps_pkg::result_t result_o
);
  import tps_pkg::*;

  dp_ctrl_t   ctrl;
  dp_status_t status;

  // sequencing controller
  tps_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .ctrl_o   (ctrl),
    .busy_o   (busy),
    .done_o   (result_valid_o)
  );

  // table and position datapath
  tps_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .ctrl_i   (ctrl),
    .status_o (status),
    .result_o (result_o)
  );

  // an accepted beat keeps the block busy
  `TPS_ASSERT(a_accept_busy, clk_i, rst_ni, start && !busy |=> busy)
  // work in flight never ends without its result beat
  `TPS_ASSERT(a_no_drop, clk_i, rst_ni, busy && !result_valid_o |=> busy)
  // a result beat is single and returns the block to idle
  `TPS_ASSERT(a_single_result, clk_i, rst_ni, result_valid_o |=> !busy && !result_valid_o)
  // nothing is in flight while reset is held
  `TPS_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !busy && !result_valid_o)

endmodule
